// ===== rtl/uep0_pkg.sv =====
// shared types, codes and constants for the endpoint-0 control stage sequencer
package uep0_pkg;

  // endpoint packet size; must be a power of two between 8 and 64
  localparam int MAX_PACKET = 64;
  localparam logic [6:0]  PKT_LEN  = 7'(MAX_PACKET);
  localparam logic [15:0] PKT_WORD = 16'(MAX_PACKET);
  localparam logic [15:0] PKT_MASK = 16'(MAX_PACKET - 1);

  // result queue depth, room for two pairs of results
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // event codes
  typedef enum logic [1:0] {
    CMD_SETUP    = 2'd0,
    CMD_IN_SENT  = 2'd1,
    CMD_OUT_DATA = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_t;

  // endpoint actions
  typedef enum logic [1:0] {
    ACT_FAIL  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // standard request numbers that are handled
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // one control endpoint event
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  endpoint;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_length;
    logic        handler_ok;
    logic        handler_direction;
    logic [15:0] handler_length;
    logic [6:0]  out_bytes;
  } event_t;

  // transfer tracking state
  typedef struct packed {
    logic [15:0] bytes_remaining;
    logic        data_direction;
    logic        zero_packet_pending;
    logic [15:0] byte_offset;
  } ep0_state_t;

  // one result command
  typedef struct packed {
    action_t     action;
    logic [6:0]  transfer_length;
    logic [15:0] data_offset;
    logic        last;
  } result_t;

  // the one or two results of an event
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } result_pair_t;

  // outcome of one event
  typedef struct packed {
    ep0_state_t   st;
    result_pair_t res;
  } step_t;

endpackage

// ===== rtl/uep0_step.sv =====
// next state and result commands for one control endpoint event
module uep0_step (
  input  uep0_pkg::event_t     ev,
  input  uep0_pkg::ep0_state_t st,
  output uep0_pkg::step_t      step
);
  import uep0_pkg::*;

  function automatic result_t mk(input action_t act, input logic [6:0] len,
                                 input logic [15:0] off);
    result_t r;
    r.action          = act;
    r.transfer_length = len;
    r.data_offset     = off;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic logic code_known(input logic [7:0] code);
    logic k;
    unique case (code)
      REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
      REQ_GET_DESCRIPTOR, REQ_GET_CONFIGURATION, REQ_SET_CONFIGURATION,
      REQ_GET_INTERFACE, REQ_SET_INTERFACE: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  // IN stage: next packet of a device-to-host transfer
  function automatic step_t in_stage(input ep0_state_t s);
    step_t o;
    logic [6:0] size;
    o.st      = s;
    o.res.r0  = mk(ACT_FAIL, 7'd0, 16'd0);
    o.res.r1  = o.res.r0;
    o.res.two = 1'b0;
    size = (s.bytes_remaining < PKT_WORD) ? s.bytes_remaining[6:0] : PKT_LEN;
    if (s.bytes_remaining == 16'd0) begin
      if (!s.data_direction) begin
        o.res.r0 = mk(ACT_NONE, 7'd0, 16'd0);
      end else if (s.zero_packet_pending) begin
        o.st.zero_packet_pending = 1'b0;
        o.res.r0 = mk(ACT_WRITE, 7'd0, 16'd0);
      end else begin
        o.res.r0 = mk(ACT_READ, PKT_LEN, 16'd0);
      end
    end else if (s.data_direction) begin
      o.res.r0  = mk(ACT_READ, 7'd0, 16'd0);
      o.res.r1  = mk(ACT_WRITE, size, s.byte_offset);
      o.res.two = 1'b1;
      o.st.byte_offset     = s.byte_offset + {9'd0, size};
      o.st.bytes_remaining = s.bytes_remaining - {9'd0, size};
    end
    return o;
  endfunction

  step_t      o;
  ep0_state_t s;
  logic       known;
  logic [15:0] rem_clamp;
  logic [15:0] got;
  logic [15:0] rem_out;
  logic [15:0] off_out;

  always_comb begin
    o.st      = st;
    o.res.r0  = mk(ACT_FAIL, 7'd0, 16'd0);
    o.res.r1  = o.res.r0;
    o.res.two = 1'b0;
    s         = '0;
    known     = (ev.request_type[6:5] == 2'd0) && code_known(ev.request_code);
    rem_clamp = (ev.handler_length > ev.request_length) ? ev.request_length
                                                        : ev.handler_length;
    got       = {9'd0, ev.out_bytes};
    rem_out   = st.bytes_remaining - got;
    off_out   = st.byte_offset + got;

    priority if (ev.endpoint != 4'd0) begin
      // foreign endpoint: fail, state kept
      o.st = st;
    end else begin
      unique case (ev.command)
        CMD_SETUP: begin
          // every setup restarts the transfer
          o.st = '0;
          if (known && ev.handler_ok) begin
            s.data_direction  = ev.handler_direction;
            s.bytes_remaining = ev.handler_length;
            o.st = s;
            if (ev.request_length != 16'd0) begin
              if (ev.request_type[7]) begin
                if (ev.handler_direction) begin
                  // device to host: clamp to wLength, zlp on short aligned transfer
                  s.bytes_remaining = rem_clamp;
                  s.zero_packet_pending = (ev.request_length > rem_clamp) &&
                                          ((rem_clamp & PKT_MASK) == 16'd0);
                  o = in_stage(s);
                end
              end else if (!ev.handler_direction &&
                           ev.handler_length == ev.request_length) begin
                // host to device: arm the first read
                o.res.r0 = mk(ACT_READ,
                              (ev.handler_length < PKT_WORD) ? ev.handler_length[6:0]
                                                             : PKT_LEN,
                              16'd0);
              end
            end else if (ev.handler_length == 16'd0) begin
              // no data stage: arm status read and send a zero-length write
              o.res.r0  = mk(ACT_READ, PKT_LEN, 16'd0);
              o.res.r1  = mk(ACT_WRITE, 7'd0, 16'd0);
              o.res.two = 1'b1;
            end
          end
        end
        CMD_IN_SENT: begin
          o = in_stage(st);
        end
        CMD_OUT_DATA: begin
          if (st.data_direction) begin
            // status stage of a device-to-host transfer
            o.res.r0 = mk(ACT_READ, PKT_LEN, 16'd0);
          end else if (got <= st.bytes_remaining) begin
            o.st.byte_offset     = off_out;
            o.st.bytes_remaining = rem_out;
            if (rem_out == 16'd0) begin
              o.res.r0 = mk(ACT_NONE, 7'd0, 16'd0);
            end else begin
              o.res.r0 = mk(ACT_READ,
                            (rem_out < PKT_WORD) ? rem_out[6:0] : PKT_LEN, off_out);
            end
          end
        end
        CMD_RESERVED: begin
          o.st = st;
        end
        default: begin
          o.st = st;
        end
      endcase
    end

    // flag the final result of this event
    if (o.res.two) begin
      o.res.r1.last = 1'b1;
    end else begin
      o.res.r0.last = 1'b1;
    end
    step = o;
  end

endmodule

// ===== rtl/uep0_result_fifo.sv =====
// small result queue loaded with one or two results at a time
module uep0_result_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  uep0_pkg::result_pair_t pair,
  input  logic                   pop_ready,
  output logic                   head_valid,
  output uep0_pkg::result_t      head,
  output logic                   can_load
);
  import uep0_pkg::*;

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic [QCNT_W-1:0]   push_n;
  logic                pop;

  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign pop        = head_valid && pop_ready;
  // room for a full pair, not counting a pop in the same cycle
  assign can_load   = (count <= QCNT_W'(QDEPTH - 2));
  assign push_n     = load ? (pair.two ? QCNT_W'(2) : QCNT_W'(1)) : '0;
  assign count_next = count + push_n - QCNT_W'(pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_n[QPTR_W-1:0];
      rptr  <= rptr + QPTR_W'(pop);
      count <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (load) begin
      mem[wptr] <= pair.r0;
      if (pair.two) begin
        mem[wptr + QPTR_W'(1)] <= pair.r1;
      end
    end
  end

endmodule

// ===== rtl/usb_ep0_control_stage_sequencer.sv =====
// top level of the endpoint-0 control stage sequencer
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    command .. out_bytes, one event
//   out      output     out_valid/out_ready  action, transfer_length, data_offset, last
//
// an event is taken into the input register, evaluated combinationally and its
// one or two results go to a four-entry result queue
// the output port moves one result a cycle while out_ready is high;
// the queue fill sets when the input stalls
// reset clears the transfer state and the queue
// a stalled output holds the head result; a held event waits for room for a pair
module usb_ep0_control_stage_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [3:0]  endpoint,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_length,
  input  logic        handler_ok,
  input  logic        handler_direction,
  input  logic [15:0] handler_length,
  input  logic [6:0]  out_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [6:0]  transfer_length,
  output logic [15:0] data_offset,
  output logic        last
);
  import uep0_pkg::*;

  event_t     ev;
  logic       held;
  logic       fire;
  logic       can_load;
  ep0_state_t st;
  step_t      step;
  result_t    head;

  assign fire     = held && can_load;
  assign in_ready = !held || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= (in_valid && in_ready) || (held && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev.command           <= command;
      ev.endpoint          <= endpoint;
      ev.request_type      <= request_type;
      ev.request_code      <= request_code;
      ev.request_length    <= request_length;
      ev.handler_ok        <= handler_ok;
      ev.handler_direction <= handler_direction;
      ev.handler_length    <= handler_length;
      ev.out_bytes         <= out_bytes;
    end
  end

  // event evaluation
  uep0_step u_step (
    .ev   (ev),
    .st   (st),
    .step (step)
  );

  // transfer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= step.st;
    end
  end

  // result queue
  uep0_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .pair       (step.res),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .can_load   (can_load)
  );

  assign action          = head.action;
  assign transfer_length = head.transfer_length;
  assign data_offset     = head.data_offset;
  assign last            = head.last;

  // an evaluated event always leaves a result at the output
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("no result after an evaluated event");

  // state only moves when an event is evaluated
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("transfer state changed without an event");

  // events for another endpoint leave the state alone
  a_foreign_ep: assert property (@(posedge clk) disable iff (rst)
    (fire && ev.endpoint != 4'd0) |=> $stable(st))
    else $error("foreign endpoint event changed state");

  // only a setup can raise the remaining byte count
  a_rem_down: assert property (@(posedge clk) disable iff (rst)
    (fire && ev.command != CMD_SETUP) |=>
      (st.bytes_remaining <= $past(st.bytes_remaining)))
    else $error("remaining bytes grew outside a setup");

endmodule
